// ===== rtl/core/bsc_pkg.sv =====
// bsc_pkg: shared types and constants for the box/sphere classifier
// no dependencies; used by the channel interfaces, bsc_axis and box_sphere_classify
`default_nettype none

package bsc_pkg;

   // field widths
   localparam int COORD_W      = 16;
   localparam int DIST_W       = 34;
   localparam int SQ_W         = 32;   // square of a 16-bit magnitude
   localparam int DIMS_DEFAULT = 4;

   // box relation codes
   typedef enum logic [1:0] {
      REL_OUTSIDE   = 2'd0,
      REL_INTERSECT = 2'd1,
      REL_INSIDE    = 2'd2
   } relation_type;

   // per-axis squared distances
   typedef struct packed {
      logic [SQ_W-1:0] near_sq;
      logic [SQ_W-1:0] far_sq;
   } axis_sq_type;

endpackage

`default_nettype wire

// ===== rtl/core/bsc_req_if.sv =====
// bsc_req_if: request channel carrying one box (low and high corners)
// depends on bsc_pkg for the coordinate width
`default_nettype none

interface bsc_req_if #(
   parameter int DIMS = bsc_pkg::DIMS_DEFAULT
);
   logic                                valid;
   logic                                ready;
   logic [DIMS*bsc_pkg::COORD_W-1:0]    low;
   logic [DIMS*bsc_pkg::COORD_W-1:0]    high;

   modport source (output valid, output low, output high, input ready);
   modport sink   (input valid, input low, input high, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bsc_rsp_if.sv =====
// bsc_rsp_if: response channel carrying the relation and both squared distances
// depends on bsc_pkg for the relation type and distance width
`default_nettype none

interface bsc_rsp_if;
   logic                          valid;
   logic                          ready;
   bsc_pkg::relation_type         relation;
   logic [bsc_pkg::DIST_W-1:0]    nearest_dist_sq;
   logic [bsc_pkg::DIST_W-1:0]    farthest_dist_sq;

   modport source (output valid, output relation, output nearest_dist_sq,
                   output farthest_dist_sq, input ready);
   modport sink   (input valid, input relation, input nearest_dist_sq,
                   input farthest_dist_sq, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bsc_axis.sv =====
// bsc_axis: one axis of the box test, gaps to the centre and their squares
// depends on bsc_pkg for widths and axis_sq_type
`default_nettype none

module bsc_axis (
   input  wire logic signed [bsc_pkg::COORD_W-1:0] low,
   input  wire logic signed [bsc_pkg::COORD_W-1:0] high,
   input  wire logic signed [bsc_pkg::COORD_W-1:0] centre,
   output bsc_pkg::axis_sq_type                    sq
);
   localparam int GAP_W = bsc_pkg::COORD_W + 1;

   logic [GAP_W-1:0]              lo_gap;
   logic [GAP_W-1:0]              hi_gap;
   logic [GAP_W-1:0]              lo_neg;
   logic [GAP_W-1:0]              hi_neg;
   logic [bsc_pkg::COORD_W-1:0]   lo_mag;
   logic [bsc_pkg::COORD_W-1:0]   hi_mag;
   logic [bsc_pkg::SQ_W-1:0]      lo_sq;
   logic [bsc_pkg::SQ_W-1:0]      hi_sq;
   logic                          lo_above;
   logic                          hi_below;

   // signed gaps, one bit wider so they never wrap
   assign lo_gap = {low[bsc_pkg::COORD_W-1], low} - {centre[bsc_pkg::COORD_W-1], centre};
   assign hi_gap = {high[bsc_pkg::COORD_W-1], high} - {centre[bsc_pkg::COORD_W-1], centre};
   assign lo_neg = -lo_gap;
   assign hi_neg = -hi_gap;

   // magnitudes fit 16 bits unsigned
   assign lo_mag = lo_gap[GAP_W-1] ? lo_neg[bsc_pkg::COORD_W-1:0] : lo_gap[bsc_pkg::COORD_W-1:0];
   assign hi_mag = hi_gap[GAP_W-1] ? hi_neg[bsc_pkg::COORD_W-1:0] : hi_gap[bsc_pkg::COORD_W-1:0];

   assign lo_sq = {{(bsc_pkg::SQ_W-bsc_pkg::COORD_W){1'b0}}, lo_mag}
                * {{(bsc_pkg::SQ_W-bsc_pkg::COORD_W){1'b0}}, lo_mag};
   assign hi_sq = {{(bsc_pkg::SQ_W-bsc_pkg::COORD_W){1'b0}}, hi_mag}
                * {{(bsc_pkg::SQ_W-bsc_pkg::COORD_W){1'b0}}, hi_mag};

   // low face above the centre, else high face below it
   assign lo_above = !lo_gap[GAP_W-1] && (lo_gap != '0);
   assign hi_below = hi_gap[GAP_W-1];

   always_comb begin
      if (lo_above) begin
         sq.near_sq = lo_sq;
      end else if (hi_below) begin
         sq.near_sq = hi_sq;
      end else begin
         sq.near_sq = '0;
      end
      sq.far_sq = (lo_sq <= hi_sq) ? hi_sq : lo_sq;
   end

endmodule

`default_nettype wire

// ===== rtl/core/box_sphere_classify.sv =====
// box_sphere_classify: classifies axis-aligned boxes against a query sphere
// depends on bsc_pkg, bsc_req_if, bsc_rsp_if and bsc_axis
//
// Usage
//   Set the sphere through the csr port: indexes 0..DIMS-1 are the centre
//   coordinates (16-bit signed), index DIMS is the squared radius (34 bits).
//   Other indexes are ignored. Write only while no request is in flight.
//   Each request on req_chan carries one box as packed low and high corners,
//   16 bits per axis, axis 0 in the low bits. Each request yields exactly one
//   response on rsp_chan: the relation (outside, intersecting, inside) and the
//   nearest and farthest squared distances, saturated at 34 bits.
// Timing
//   Three register stages: request register, per-axis squares, response
//   register. An accepted request passes through them in that order; a stall can hold it in any stage.
//   One request per cycle is sustained; the rate is set by the stage chain
//   advancing every cycle while the response side takes data.
// Reset and stall
//   Reset empties all stages and clears the centre and radius to zero.
//   When rsp_chan.ready is low the response holds and the stages behind it
//   fill; req_chan.ready drops only once all three stages are occupied.
`default_nettype none

module box_sphere_classify #(
   parameter int DIMS = bsc_pkg::DIMS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   bsc_req_if.sink                                req_chan,
   bsc_rsp_if.source                              rsp_chan,
   input  wire logic                              csr_we,
   input  wire logic [$clog2(DIMS+1)-1:0]         csr_index,
   input  wire logic [bsc_pkg::DIST_W-1:0]        csr_wdata
);
   localparam int IDX_W  = $clog2(DIMS + 1);
   localparam int SUM_W  = bsc_pkg::SQ_W + $clog2(DIMS);
   localparam int CMP_W  = (SUM_W > bsc_pkg::DIST_W) ? SUM_W : bsc_pkg::DIST_W;
   localparam int CW     = bsc_pkg::COORD_W;

   // sphere registers
   logic signed [CW-1:0]           centre_ff [DIMS];
   logic [bsc_pkg::DIST_W-1:0]     radius_ff;

   // stage valids and payloads
   logic                           s0_v_ff;
   logic [DIMS*CW-1:0]             s0_low_ff;
   logic [DIMS*CW-1:0]             s0_high_ff;
   logic                           s1_v_ff;
   bsc_pkg::axis_sq_type           s1_sq_ff [DIMS];
   bsc_pkg::axis_sq_type           s1_sq_in [DIMS];
   logic                           out_v_ff;
   bsc_pkg::relation_type          rel_ff;
   bsc_pkg::relation_type          rel_in;
   logic [bsc_pkg::DIST_W-1:0]     near_ff;
   logic [bsc_pkg::DIST_W-1:0]     near_in;
   logic [bsc_pkg::DIST_W-1:0]     far_ff;
   logic [bsc_pkg::DIST_W-1:0]     far_in;

   logic                           adv0;
   logic                           adv1;
   logic                           adv2;
   logic [SUM_W-1:0]               near_sum;
   logic [SUM_W-1:0]               far_sum;
   logic [CMP_W-1:0]               near_ext;
   logic [CMP_W-1:0]               far_ext;
   logic [CMP_W-1:0]               radius_ext;
   logic [CMP_W-1:0]               dist_max_ext;

   // stage advance chain
   assign adv2 = !out_v_ff || rsp_chan.ready;
   assign adv1 = !s1_v_ff || adv2;
   assign adv0 = !s0_v_ff || adv1;
   assign req_chan.ready = adv0;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIMS; i++) begin
            centre_ff[i] <= '0;
         end
         radius_ff <= '0;
      end else if (csr_we) begin
         for (int i = 0; i < DIMS; i++) begin
            if (csr_index == IDX_W'(i)) begin
               centre_ff[i] <= csr_wdata[CW-1:0];
            end
         end
         if (csr_index == IDX_W'(DIMS)) begin
            radius_ff <= csr_wdata;
         end
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (adv0) begin
         s0_v_ff <= req_chan.valid;
      end
      if (adv0 && req_chan.valid) begin
         s0_low_ff  <= req_chan.low;
         s0_high_ff <= req_chan.high;
      end
   end

   // per-axis gaps and squares
   for (genvar g = 0; g < DIMS; g++) begin : g_axis
      bsc_axis u_axis (
         .low    (s0_low_ff[g*CW +: CW]),
         .high   (s0_high_ff[g*CW +: CW]),
         .centre (centre_ff[g]),
         .sq     (s1_sq_in[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv1) begin
         s1_v_ff <= s0_v_ff;
      end
      if (adv1 && s0_v_ff) begin
         for (int i = 0; i < DIMS; i++) begin
            s1_sq_ff[i] <= s1_sq_in[i];
         end
      end
   end

   // sums, classification and saturation
   always_comb begin
      near_sum = '0;
      far_sum  = '0;
      for (int i = 0; i < DIMS; i++) begin
         near_sum = near_sum + SUM_W'(s1_sq_ff[i].near_sq);
         far_sum  = far_sum + SUM_W'(s1_sq_ff[i].far_sq);
      end
      near_ext     = CMP_W'(near_sum);
      far_ext      = CMP_W'(far_sum);
      radius_ext   = CMP_W'(radius_ff);
      dist_max_ext = CMP_W'({bsc_pkg::DIST_W{1'b1}});

      if (near_ext <= radius_ext) begin
         rel_in = (far_ext <= radius_ext) ? bsc_pkg::REL_INSIDE : bsc_pkg::REL_INTERSECT;
      end else begin
         rel_in = bsc_pkg::REL_OUTSIDE;
      end
      near_in = (near_ext > dist_max_ext) ? '1 : near_ext[bsc_pkg::DIST_W-1:0];
      far_in  = (far_ext > dist_max_ext) ? '1 : far_ext[bsc_pkg::DIST_W-1:0];
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv2) begin
         out_v_ff <= s1_v_ff;
      end
      if (adv2 && s1_v_ff) begin
         rel_ff  <= rel_in;
         near_ff <= near_in;
         far_ff  <= far_in;
      end
   end

   assign rsp_chan.valid            = out_v_ff;
   assign rsp_chan.relation         = rel_ff;
   assign rsp_chan.nearest_dist_sq  = near_ff;
   assign rsp_chan.farthest_dist_sq = far_ff;

   // nearest point never lies beyond the farthest face sum
   a_near_le_far: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> (near_ff <= far_ff))
      else $error("nearest distance exceeds farthest distance");

   // outside means the nearest point is at or past the radius
   a_outside_near: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && rel_ff == bsc_pkg::REL_OUTSIDE) |-> (near_ff >= radius_ff))
      else $error("outside box with nearest distance inside radius");

   // intersecting or inside means the nearest point is within the radius
   a_touch_near: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && (rel_ff == bsc_pkg::REL_INTERSECT || rel_ff == bsc_pkg::REL_INSIDE))
      |-> (near_ff <= radius_ff))
      else $error("touching box with nearest distance beyond radius");

   // inside means the farthest corner is within the radius
   a_inside_far: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && rel_ff == bsc_pkg::REL_INSIDE) |-> (far_ff <= radius_ff))
      else $error("inside box with farthest distance beyond radius");

   // an accepted request always occupies the first stage next cycle
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> s0_v_ff)
      else $error("accepted request lost before first stage");

endmodule

`default_nettype wire
